// File: src/thq_pkg.sv
// Shared constants and types for the timer heap queue.
package thq_pkg;
  localparam int HeapDepth = 32;
  localparam int TimeWidth = 48;
  localparam int IdxW = $clog2(HeapDepth);
  localparam int CntW = $clog2(HeapDepth + 1);

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFull    = 2'd1;
  localparam logic [1:0] StatusExpired = 2'd2;

  localparam logic CmdSchedule = 1'b0;
  localparam logic CmdAdvance  = 1'b1;

  typedef enum logic [2:0] {
    OpNone,
    OpLoad,
    OpUpRead,
    OpUpStep,
    OpDnStart,
    OpDnRead,
    OpDnStep
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic top_due;
    logic done;
    logic [7:0] top_tag;
  } dp_stat_t;
endpackage

// File: src/thq_datapath.sv
// Heap storage, count register and sift-up / sift-down datapath.
module thq_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  thq_pkg::dp_cmd_t       cmd_i,
  input  logic [47:0]            time_value_i,
  input  logic [7:0]             timer_tag_i,
  output thq_pkg::dp_stat_t      stat_o
);
  import thq_pkg::*;

  logic [TimeWidth-1:0] mem_time [HeapDepth];
  logic [7:0]           mem_tag  [HeapDepth];

  logic [CntW-1:0]      count_q, count_d;
  logic [IdxW:0]        pos_q, pos_d;
  logic [IdxW:0]        last_q;
  logic [TimeWidth-1:0] mv_time_q, now_q;
  logic [7:0]           mv_tag_q;
  logic [TimeWidth-1:0] root_time_q;
  logic [7:0]           root_tag_q;
  // Registered reads: a (parent or left child) and b (right child).
  logic [TimeWidth-1:0] rd_a_time_q, rd_b_time_q;
  logic [7:0]           rd_a_tag_q, rd_b_tag_q;
  logic                 done_q;

  logic                 wr_en;
  logic [IdxW-1:0]      wr_idx;
  logic [TimeWidth-1:0] wr_time;
  logic [7:0]           wr_tag;
  logic [IdxW+1:0]      child;
  logic                 have_l, have_r, take_l, take_r, chose;
  logic [IdxW:0]        best;
  logic [TimeWidth-1:0] best_time;
  logic [IdxW:0]        parent;

  assign child  = {pos_q, 1'b0} + (IdxW+2)'(1);
  assign parent = (pos_q - (IdxW+1)'(1)) >> 1;
  assign have_l = child < (IdxW+2)'(count_q);
  assign have_r = (child + (IdxW+2)'(1)) < (IdxW+2)'(count_q);

  always_comb begin
    take_l    = have_l && (rd_a_time_q <= mv_time_q);
    best      = take_l ? child[IdxW:0] : '0;
    best_time = take_l ? rd_a_time_q : mv_time_q;
    take_r    = have_r && (rd_b_time_q <= best_time);
    if (take_r) best = child[IdxW:0] + (IdxW+1)'(1);
    chose     = take_l || take_r;
  end

  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    wr_en   = 1'b0;
    wr_idx  = pos_q[IdxW-1:0];
    wr_time = mv_time_q;
    wr_tag  = mv_tag_q;
    case (cmd_i.op)
      OpLoad: pos_d = (IdxW+1)'(count_q);
      OpUpStep: begin
        if (pos_q != '0 && rd_a_time_q > mv_time_q) begin
          wr_en = 1'b1; wr_time = rd_a_time_q; wr_tag = rd_a_tag_q;
          pos_d = parent;
        end else begin
          wr_en = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end
      OpDnStart: pos_d = '0;
      OpDnStep: begin
        wr_en = 1'b1;
        if (!chose || best == last_q) begin
          count_d = count_q - CntW'(1);
        end else begin
          wr_time = take_r ? rd_b_time_q : rd_a_time_q;
          wr_tag  = take_r ? rd_b_tag_q : rd_a_tag_q;
          pos_d   = best;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_time[wr_idx] <= wr_time;
      mem_tag[wr_idx]  <= wr_tag;
    end
    case (cmd_i.op)
      OpLoad: begin
        mv_time_q <= time_value_i[TimeWidth-1:0];
        mv_tag_q  <= timer_tag_i;
        now_q     <= time_value_i[TimeWidth-1:0];
      end
      OpUpRead: rd_a_time_q <= mem_time[parent[IdxW-1:0]];
      OpDnStart: begin
        mv_time_q <= mem_time[last_q[IdxW-1:0]];
        mv_tag_q  <= mem_tag[last_q[IdxW-1:0]];
      end
      OpDnRead: begin
        rd_a_time_q <= mem_time[child[IdxW-1:0]];
        rd_a_tag_q  <= mem_tag[child[IdxW-1:0]];
        rd_b_time_q <= mem_time[child[IdxW-1:0] + IdxW'(1)];
        rd_b_tag_q  <= mem_tag[child[IdxW-1:0] + IdxW'(1)];
      end
      default: ;
    endcase
    if (cmd_i.op == OpUpRead) rd_a_tag_q <= mem_tag[parent[IdxW-1:0]];
    root_time_q <= mem_time[0];
    root_tag_q  <= mem_tag[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
      last_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
      last_q  <= (IdxW+1)'(count_q) - (IdxW+1)'(1);
      done_q  <= (cmd_i.op == OpUpStep || cmd_i.op == OpDnStep) &&
                 (count_d != count_q);
    end
  end

  assign stat_o.full    = count_q == CntW'(HeapDepth);
  assign stat_o.empty   = count_q == '0;
  assign stat_o.top_due = !(root_time_q > now_q);
  assign stat_o.top_tag = root_tag_q;
  assign stat_o.done    = done_q;
endmodule

// File: src/thq_ctrl.sv
// Sequencer for schedule and advance transactions and the output register.
module thq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic                   command_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output logic [1:0]             status_o,
  output logic [7:0]             expired_tag_o,
  output logic                   last_o,
  output thq_pkg::dp_cmd_t       dp_cmd_o,
  input  thq_pkg::dp_stat_t      dp_stat_i
);
  import thq_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StUpRead, StUpStep, StUpWait, StAdvWait, StAdvChk,
    StDnStart, StDnRead, StDnStep, StDnWait, StOut
  } state_e;

  state_e state_q;
  logic   valid_q;

  always_comb begin
    dp_cmd_o.op = OpNone;
    case (state_q)
      StIdle:    if (valid_i && !valid_q) dp_cmd_o.op = OpLoad;
      StUpRead:  dp_cmd_o.op = OpUpRead;
      StUpStep:  dp_cmd_o.op = OpUpStep;
      StDnStart: dp_cmd_o.op = OpDnStart;
      StDnRead:  dp_cmd_o.op = OpDnRead;
      StDnStep:  dp_cmd_o.op = OpDnStep;
      default: ;
    endcase
  end

  assign stall_o = (state_q != StIdle) || valid_q;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      valid_q       <= 1'b0;
      status_o      <= StatusOk;
      expired_tag_o <= '0;
      last_o        <= 1'b0;
    end else begin
      // The advance check reloads the output register itself when it frees up.
      if (valid_q && !stall_i && state_q != StAdvChk) valid_q <= 1'b0;
      case (state_q)
        StIdle: if (valid_i && !valid_q) begin
          if (command_i == CmdAdvance) state_q <= StAdvWait;
          else if (dp_stat_i.full) begin
            valid_q <= 1'b1; status_o <= StatusFull;
            expired_tag_o <= '0; last_o <= 1'b1;
          end else state_q <= StUpRead;
        end
        StUpRead: state_q <= StUpStep;
        StUpStep: state_q <= StUpWait;
        StUpWait: begin
          if (dp_stat_i.done) begin
            valid_q <= 1'b1; status_o <= StatusOk;
            expired_tag_o <= '0; last_o <= 1'b1;
            state_q <= StIdle;
          end else state_q <= StUpRead;
        end
        StAdvWait: state_q <= StAdvChk;
        StAdvChk: begin
          if (!valid_q || !stall_i) begin
            valid_q <= 1'b1;
            if (!dp_stat_i.empty && dp_stat_i.top_due) begin
              status_o <= StatusExpired; expired_tag_o <= dp_stat_i.top_tag;
              last_o <= 1'b0; state_q <= StDnStart;
            end else begin
              status_o <= StatusOk; expired_tag_o <= '0;
              last_o <= 1'b1; state_q <= StIdle;
            end
          end
        end
        StDnStart: state_q <= StDnRead;
        StDnRead:  state_q <= StDnStep;
        StDnStep:  state_q <= StDnWait;
        StDnWait: state_q <= dp_stat_i.done ? StOut : StDnRead;
        StOut: state_q <= StAdvWait;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// File: src/timer_heap_queue.sv
// Top level of the timer heap queue.
// Timer queue held as a 32-entry binary min-heap on 48-bit expiry ticks. A
// schedule transaction inserts and sifts up, taking per level the steps read
// parent, compare and move, and settle; a full heap gives one rejected result
// at once. An advance transaction gives one expired result per due timer,
// each followed by a sift-down that visits one to five heap levels, and
// closes with a done result; a result may wait in the output register until
// it is taken. The heap memory reads are registered, and a waiting result
// holds off the next transaction.
module timer_heap_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        command_i,
  input  logic [47:0] time_value_i,
  input  logic [7:0]  timer_tag_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  expired_tag_o,
  output logic        last_o
);
  import thq_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  thq_ctrl u_ctrl (
    .clk_i, .rst_ni, .valid_i, .stall_o, .command_i, .valid_o, .stall_i,
    .status_o, .expired_tag_o, .last_o,
    .dp_cmd_o(dp_cmd), .dp_stat_i(dp_stat)
  );

  thq_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .time_value_i, .timer_tag_i,
    .stat_o(dp_stat)
  );
endmodule

// File: dv/thq_checker.sv
// Checker for the timer heap queue: predicts results from input transactions and compares.
module thq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic        command_i,
  input  logic [47:0] time_value_i,
  input  logic [7:0]  timer_tag_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic [1:0]  status_o,
  input  logic [7:0]  expired_tag_o,
  input  logic        last_o,
  output int          fail_count,
  output int          pending_count,
  output int          results_seen,
  output int          expired_seen,
  output int          full_seen
);
  import thq_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] tag;
    logic       last;
  } timer_result_t;

  logic [TimeWidth-1:0] exp_time [HeapDepth];
  logic [7:0]           exp_tag  [HeapDepth];
  int                   heap_size;
  timer_result_t        due_results [$];

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic timer_result_t mk(input logic [1:0] s, input logic [7:0] t, input logic l);
    timer_result_t r;
    r.status = s;
    r.tag = t;
    r.last = l;
    return r;
  endfunction

  // Root removal: the last entry sinks from the root, preferring equal or right children.
  task automatic pop_root();
    int n, last_idx, pos, child, best;
    logic chose;
    logic [TimeWidth-1:0] mv_t, best_t;
    logic [7:0] mv_g;
    n = heap_size;
    last_idx = n - 1;
    mv_t = exp_time[last_idx];
    mv_g = exp_tag[last_idx];
    pos = 0;
    forever begin
      child = 2 * pos + 1;
      chose = 1'b0;
      best = 0;
      best_t = mv_t;
      if (child < n && exp_time[child] <= best_t) begin
        best = child;
        best_t = exp_time[child];
        chose = 1'b1;
      end
      if (child + 1 < n && exp_time[child+1] <= best_t) begin
        best = child + 1;
        best_t = exp_time[child+1];
        chose = 1'b1;
      end
      if (!chose || best == last_idx) begin
        exp_time[pos] = mv_t;
        exp_tag[pos] = mv_g;
        break;
      end
      exp_time[pos] = exp_time[best];
      exp_tag[pos] = exp_tag[best];
      pos = best;
    end
  endtask

  task automatic predict_transaction(input logic cmd, input logic [47:0] tv,
                                     input logic [7:0] tg);
    int pos, parent;
    if (cmd == CmdSchedule) begin
      if (heap_size >= HeapDepth) begin
        due_results.push_back(mk(StatusFull, 8'd0, 1'b1));
      end else begin
        pos = heap_size;
        heap_size++;
        while (pos > 0) begin
          parent = (pos - 1) >> 1;
          if (!(exp_time[parent] > tv)) break;
          exp_time[pos] = exp_time[parent];
          exp_tag[pos] = exp_tag[parent];
          pos = parent;
        end
        exp_time[pos] = tv;
        exp_tag[pos] = tg;
        due_results.push_back(mk(StatusOk, 8'd0, 1'b1));
      end
    end else begin
      while (heap_size > 0 && !(exp_time[0] > tv)) begin
        due_results.push_back(mk(StatusExpired, exp_tag[0], 1'b0));
        pop_root();
        heap_size--;
      end
      due_results.push_back(mk(StatusOk, 8'd0, 1'b1));
    end
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    heap_size = 0;
    results_seen = 0;
    expired_seen = 0;
    full_seen = 0;
  end

  always @(posedge clk_i) begin
    timer_result_t want;
    if (rst_ni) begin
      if (valid_i && !stall_o) predict_transaction(command_i, time_value_i, timer_tag_i);
      if (valid_o && !stall_i) begin
        results_seen++;
        if (status_o == StatusExpired) expired_seen++;
        if (status_o == StatusFull) full_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
          if (expired_tag_o !== want.tag)
            report_mismatch($sformatf("tag %0d, want %0d", expired_tag_o, want.tag));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
        end
      end
      pending_count = due_results.size();
    end
  end
endmodule

// File: dv/testbench.sv
// Top of the timer heap queue testbench: clock, reset, stimulus and verdict.
module testbench;
  import thq_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic        command_i = 1'b0;
  logic [47:0] time_value_i = '0;
  logic [7:0]  timer_tag_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  expired_tag_o;
  logic        last_o;

  int fail_count, pending_count, results_seen, expired_seen, full_seen;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  longint cycle_count = 0;
  logic [47:0] now_ticks = '0;

  localparam longint CycleLimit = 2000000;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  timer_heap_queue dut (.*);

  thq_checker checker_i (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stall, redrawn at every falling edge.
  always @(negedge clk_i) begin
    stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so the next call or the caller decides whether it drops.
  task automatic send_item(input logic cmd, input logic [47:0] tv, input logic [7:0] tg);
    while ($urandom_range(99) < idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    command_i <= cmd;
    time_value_i <= tv;
    timer_tag_i <= tg;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic schedule(input logic [47:0] tv);
    send_item(CmdSchedule, tv, 8'($urandom));
  endtask

  task automatic advance(input logic [47:0] tv);
    send_item(CmdAdvance, tv, 8'($urandom));
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic set_phase(input int p);
    case (p % 4)
      0: begin idle_pct = 0; stall_pct = 0; end
      1: begin idle_pct = 68; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 68; end
      default: begin idle_pct = 22; stall_pct = 22; end
    endcase
  endtask

  initial begin
    int n, k;
    logic [47:0] t;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty advance, extremes, ties, full heap, drain.
    advance('0);
    schedule('0);
    send_item(CmdSchedule, 48'hFFFF_FFFF_FFFF, 8'hFF);
    send_item(CmdSchedule, 48'd5, 8'h00);
    send_item(CmdSchedule, 48'd5, 8'hA5);
    send_item(CmdSchedule, 48'd5, 8'h5A);
    advance(48'd4);
    advance(48'd5);
    for (int i = 0; i < 30; i++) schedule(48'(i % 3));
    schedule(48'd1);
    send_item(CmdSchedule, 48'd7, 8'hFF);
    advance(48'hFFFF_FFFF_FFFE);
    advance(48'hFFFF_FFFF_FFFF);

    // Random: bursts of schedules with times near a moving clock, then advances.
    for (int ph = 0; sent < 420; ph++) begin
      set_phase(ph);
      for (int b = 0; b < 6; b++) begin
        n = $urandom_range(1, 12);
        if ($urandom_range(9) == 0) n = 36;
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(9))
            0: t = rand48();
            1: t = now_ticks;
            default: t = now_ticks + 48'($urandom_range(0, 40));
          endcase
          if ($urandom_range(19) == 0) advance(rand48() & 48'h0000_0000_FFFF);
          else schedule(t);
        end
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) begin
          now_ticks = now_ticks + 48'($urandom_range(0, 25));
          advance(now_ticks);
        end
      end
      if ($urandom_range(3) == 0) begin
        advance(48'hFFFF_FFFF_FFFF);
        now_ticks = '0;
      end
    end
    valid_i <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d transactions; %0d results checked, %0d expirations, %0d full rejects.",
             sent, results_seen, expired_seen, full_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
